>>> rtl/lspe_pkg.sv
// Shared types, codes and constants of the line sensor position estimator.
package lspe_pkg;

	// Defaults of the top-level parameters.
	localparam int DEF_MAX_SENSORS = 32;
	localparam int DEF_SAMPLE_BITS = 10;

	// Fixed field widths.
	localparam int CMD_W      = 2;
	localparam int INDEX_W    = 5;
	localparam int CAL_W      = 10;
	localparam int POS_W      = 16;
	localparam int COUNT_W    = 6;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	// Accumulator widths; sums wrap at these widths.
	localparam int WSUM_W = 30;
	localparam int WGT_W  = 15;

	// Calibration and detection constants.
	localparam int SCALE_FULL     = 1000;
	localparam int NOISE_FLOOR    = 50;
	localparam int AUTO_THRESHOLD = 500;
	localparam int COUNT_RESET    = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_CAL   = 2'd0,
		CMD_MEAS  = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_DARK  = 2'd0,
		MODE_LIGHT = 2'd1,
		MODE_AUTO  = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENSOR_COUNT = 2'd0,
		REG_LINE_MODE    = 2'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_DIV_SCALE,
		S_ACC_DARK,
		S_ACC_LIGHT,
		S_POS,
		S_DIV_POS,
		S_DONE
	} state_t;

endpackage

>>> rtl/lspe_if.sv
// Channel interfaces of the line sensor position estimator: items, results, register writes.
interface lspe_item_if import lspe_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
	logic                   valid;
	logic                   ready;
	logic [CMD_W-1:0]       command;
	logic [INDEX_W-1:0]     sensor_index;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   restart_calibration;

	modport source (output valid, command, sensor_index, sample, restart_calibration,
		input ready);
	modport sink (input valid, command, sensor_index, sample, restart_calibration,
		output ready);
endinterface

interface lspe_result_if import lspe_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
	logic                    valid;
	logic                    ready;
	logic [CAL_W-1:0]        calibrated_value;
	logic [SAMPLE_BITS-1:0]  calib_min;
	logic [SAMPLE_BITS-1:0]  calib_max;
	logic signed [POS_W-1:0] position;
	logic                    position_valid;

	modport source (output valid, calibrated_value, calib_min, calib_max, position,
		position_valid, input ready);
	modport sink (input valid, calibrated_value, calib_min, calib_max, position,
		position_valid, output ready);
endinterface

interface lspe_cfg_if import lspe_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/line_sensor_position_estimator.sv
// Top level of the line sensor position estimator: sequencer, tables, accumulators.
//
//  Channel  Dir  Handshake      Payload
//  item     in   valid/ready    command, sensor_index, sample, restart_calibration
//  result   out  valid/ready    calibrated_value, calib_min, calib_max, position,
//                               position_valid
//  cfg      in   valid/ready    index (register number), data
//
// A calibration or query transaction passes the prepare state and loads its result from
// the final state. A measurement with a proper range makes one 30-step pass of the
// shared restoring divider before its dark and light accumulate states; with equal or
// inverted bounds or an unknown sensor it skips the divider.
// The last sensor of a sweep adds a second 30-step pass for the position quotient
// when the selected weight sum is nonzero.
// The block takes one item at a time; the result register lets the next item be
// accepted while the previous result still waits to be taken.
// Reset clears the calibration tables to full-scale minimum and zero maximum,
// the accumulators, and loads a sensor count of 8 and dark-line mode.
// A stalled result holds the sequencer in its final state until the register frees.
module line_sensor_position_estimator import lspe_pkg::*; #(
	parameter int MAX_SENSORS = DEF_MAX_SENSORS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	lspe_item_if.sink     item,
	lspe_result_if.source result,
	lspe_cfg_if.sink      cfg
);
	localparam int TBL_AW      = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
	localparam int SCALE_NUM_W = SAMPLE_BITS + CAL_W;
	localparam int PROD_W      = CAL_W + WGT_W;

	state_t state_q, state_d;

	// Captured item.
	cmd_t                   cmd_q;
	logic [INDEX_W-1:0]     idx_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic                   restart_q;
	logic [WGT_W-1:0]       idxk_q;

	// Configuration registers.
	logic [COUNT_W-1:0] count_q;
	logic [MODE_W-1:0]  mode_q;

	// Calibration tables, one entry per sensor.
	logic [SAMPLE_BITS-1:0] min_q [MAX_SENSORS];
	logic [SAMPLE_BITS-1:0] max_q [MAX_SENSORS];

	// Sweep accumulators.
	logic [WSUM_W-1:0] dark_ws_q, light_ws_q;
	logic [WGT_W-1:0]  dark_w_q, light_w_q, bright_q;

	// Per-item working results.
	logic [CAL_W-1:0]        calv_q;
	logic signed [POS_W-1:0] pos_q;
	logic                    posv_q;

	// Result register.
	logic                    res_valid_q;
	logic [CAL_W-1:0]        res_calv_q;
	logic [SAMPLE_BITS-1:0]  res_min_q, res_max_q;
	logic signed [POS_W-1:0] res_pos_q;
	logic                    res_posv_q;

	// Shared divider.
	logic              div_start;
	logic [WSUM_W-1:0] div_num;
	logic [WGT_W-1:0]  div_den;
	logic              div_done;
	logic [WSUM_W-1:0] div_quot;

	logic                   item_acc;
	logic                   res_load;
	logic                   in_range;
	logic [TBL_AW-1:0]      tbl_addr;
	logic [SAMPLE_BITS-1:0] lo_rd, hi_rd, clamp_v, span;
	logic [WSUM_W-1:0]      scale_num;
	logic [COUNT_W-1:0]     cnt_eff;
	logic                   last_idx;
	logic                   auto_light, use_light;
	logic [WSUM_W-1:0]      sel_ws;
	logic [WGT_W-1:0]       sel_w;
	logic [CAL_W-1:0]       light_val, acc_val;
	logic [PROD_W-1:0]      prod;
	logic                   above_floor;
	logic [WSUM_W-1:0]      prod_add;
	logic [WGT_W-1:0]       val_add;
	logic                   clear_sweep;

	assign item_acc = item.valid && item.ready;
	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// Table lookup for the addressed sensor; sensors beyond the table read as zero.
	assign in_range = {1'b0, idx_q} < (INDEX_W + 1)'(MAX_SENSORS);
	assign tbl_addr = idx_q[TBL_AW-1:0];
	assign lo_rd    = in_range ? min_q[tbl_addr] : '0;
	assign hi_rd    = in_range ? max_q[tbl_addr] : '0;

	// Clamp to the calibrated range, low bound tested first, then scale to 0..1000.
	assign clamp_v   = (sample_q < lo_rd) ? lo_rd : ((sample_q > hi_rd) ? hi_rd : sample_q);
	assign span      = hi_rd - lo_rd;
	assign scale_num = WSUM_W'(SCALE_NUM_W'(clamp_v - lo_rd) * SCALE_NUM_W'(SCALE_FULL));

	// Effective sweep length is the configured count held within 1..MAX_SENSORS.
	always_comb begin
		if (count_q == '0) begin
			cnt_eff = COUNT_W'(1);
		end else if (count_q > COUNT_W'(MAX_SENSORS)) begin
			cnt_eff = COUNT_W'(MAX_SENSORS);
		end else begin
			cnt_eff = count_q;
		end
	end
	assign last_idx = COUNT_W'(idx_q) == (cnt_eff - COUNT_W'(1));

	// The mean exceeds the threshold exactly when the total reaches (threshold+1) times
	// the count, so no division is needed for auto mode.
	assign auto_light = {1'b0, bright_q} >=
		(WGT_W + 1)'(cnt_eff) * (WGT_W + 1)'(AUTO_THRESHOLD + 1);

	always_comb begin
		case (mode_q)
			MODE_DARK:  use_light = 1'b0;
			MODE_LIGHT: use_light = 1'b1;
			default:    use_light = auto_light;
		endcase
	end
	assign sel_ws = use_light ? light_ws_q : dark_ws_q;
	assign sel_w  = use_light ? light_w_q : dark_w_q;

	// One multiplier serves the dark pass and then the light pass.
	assign light_val   = CAL_W'(SCALE_FULL) - calv_q;
	assign acc_val     = (state_q == S_ACC_LIGHT) ? light_val : calv_q;
	assign prod        = PROD_W'(acc_val) * PROD_W'(idxk_q);
	assign above_floor = acc_val > CAL_W'(NOISE_FLOOR);
	assign prod_add    = above_floor ? WSUM_W'(prod) : '0;
	assign val_add     = above_floor ? WGT_W'(acc_val) : '0;
	assign clear_sweep = (idx_q == '0);

	assign res_load = (state_q == S_DONE) && (!res_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_num   = scale_num;
		div_den   = WGT_W'(span);
		unique case (state_q)
			S_IDLE: begin
				if (item.valid) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				case (cmd_q)
					CMD_MEAS: begin
						// A proper range goes through the divider; equal or inverted
						// bounds and unknown sensors are settled right away.
						if (in_range && (lo_rd < hi_rd)) begin
							div_start = 1'b1;
							state_d   = S_DIV_SCALE;
						end else begin
							state_d = S_ACC_DARK;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_DIV_SCALE: begin
				if (div_done) begin
					state_d = S_ACC_DARK;
				end
			end
			S_ACC_DARK: state_d = S_ACC_LIGHT;
			S_ACC_LIGHT: state_d = last_idx ? S_POS : S_DONE;
			S_POS: begin
				div_num = sel_ws;
				div_den = sel_w;
				if (sel_w != '0) begin
					div_start = 1'b1;
					state_d   = S_DIV_POS;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIV_POS: begin
				div_num = sel_ws;
				div_den = sel_w;
				if (div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Configuration writes; indices beyond the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_W'(COUNT_RESET);
			mode_q  <= MODE_DARK;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_SENSOR_COUNT: count_q <= cfg.data[COUNT_W-1:0];
				REG_LINE_MODE:    mode_q  <= cfg.data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Item capture and per-item results.
	always_ff @(posedge clk) begin
		if (item_acc) begin
			cmd_q     <= cmd_t'(item.command);
			idx_q     <= item.sensor_index;
			sample_q  <= item.sample;
			restart_q <= item.restart_calibration;
			idxk_q    <= WGT_W'(item.sensor_index) * WGT_W'(SCALE_FULL);
			calv_q    <= '0;
			pos_q     <= '0;
			posv_q    <= 1'b0;
		end else begin
			if ((state_q == S_PREP) && (cmd_q == CMD_MEAS)) begin
				// An inverted range gives full scale unless the sample is below min.
				calv_q <= (in_range && (lo_rd > hi_rd) && (sample_q >= lo_rd)) ?
					CAL_W'(SCALE_FULL) : '0;
			end
			if ((state_q == S_DIV_SCALE) && div_done) begin
				calv_q <= div_quot[CAL_W-1:0];
			end
			if (state_q == S_POS) begin
				posv_q <= 1'b1;
				if (sel_w == '0) begin
					pos_q <= '1;
				end
			end
			if ((state_q == S_DIV_POS) && div_done) begin
				pos_q <= div_quot[POS_W-1:0];
			end
		end
	end

	// Calibration tables.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SENSORS; i++) begin
				min_q[i] <= '1;
				max_q[i] <= '0;
			end
		end else if ((state_q == S_PREP) && (cmd_q == CMD_CAL) && in_range) begin
			if (restart_q) begin
				min_q[tbl_addr] <= sample_q;
				max_q[tbl_addr] <= sample_q;
			end else begin
				if (sample_q < lo_rd) begin
					min_q[tbl_addr] <= sample_q;
				end
				if (sample_q > hi_rd) begin
					max_q[tbl_addr] <= sample_q;
				end
			end
		end
	end

	// Sweep accumulators; sensor zero starts a new sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_ws_q  <= '0;
			dark_w_q   <= '0;
			light_ws_q <= '0;
			light_w_q  <= '0;
			bright_q   <= '0;
		end else if (state_q == S_ACC_DARK) begin
			dark_ws_q <= (clear_sweep ? '0 : dark_ws_q) + prod_add;
			dark_w_q  <= (clear_sweep ? '0 : dark_w_q) + val_add;
			bright_q  <= (clear_sweep ? '0 : bright_q) + WGT_W'(calv_q);
			if (clear_sweep) begin
				light_ws_q <= '0;
				light_w_q  <= '0;
			end
		end else if (state_q == S_ACC_LIGHT) begin
			light_ws_q <= light_ws_q + prod_add;
			light_w_q  <= light_w_q + val_add;
		end
	end

	// Result register; the bounds are read after any table update of this item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_calv_q <= calv_q;
			res_min_q  <= lo_rd;
			res_max_q  <= hi_rd;
			res_pos_q  <= pos_q;
			res_posv_q <= posv_q;
		end
	end

	assign result.valid            = res_valid_q;
	assign result.calibrated_value = res_calv_q;
	assign result.calib_min        = res_min_q;
	assign result.calib_max        = res_max_q;
	assign result.position         = res_pos_q;
	assign result.position_valid   = res_posv_q;

	lspe_div #(
		.NUM_W(WSUM_W),
		.DEN_W(WGT_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |=> state_q == S_PREP)
		else $error("accepted transaction did not start the sequencer");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_DONE))
		else $error("result appeared outside the final state");
	a_calv_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_calv_q <= CAL_W'(SCALE_FULL))
		else $error("calibrated value above full scale");
	a_pos_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && posv_q |-> (cmd_q == CMD_MEAS) && last_idx)
		else $error("position reported on a transaction that does not end a sweep");
endmodule

>>> rtl/lspe_div.sv
// Restoring divider, one quotient bit per cycle, shared by scaling and position.
module lspe_div import lspe_pkg::*; #(
	parameter int NUM_W = WSUM_W,
	parameter int DEN_W = WGT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// The dividend shifts out at the top while quotient bits shift in at the bottom.
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_last_step_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && (cnt_q == CNT_W'(1)) && !start |=> done_q && !busy_q)
		else $error("divider did not finish after its last step");
	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(start))
		else $error("divider became busy without a start");
endmodule

>>> tb/sv/line_sensor_position_estimator_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the line sensor position estimator with its own behavioral predictor.
module line_sensor_position_estimator_test;
	import lspe_pkg::*;

	localparam int MAX_SENSORS = DEF_MAX_SENSORS;
	localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
	localparam int unsigned FULL_CODE = (1 << SAMPLE_BITS) - 1;
	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 10;
	localparam int DRAIN_CYCLES = 100;
	localparam int MISMATCH_REPORTS = 10;
	localparam int RANDOM_TARGET = 1340;

	// Codes outside the named sets; the block treats them as query, auto and no register.
	localparam cmd_t CMD_SPARE = cmd_t'(2'd3);
	localparam mode_t MODE_SPARE = mode_t'(2'd3);
	localparam reg_idx_t REG_SPARE = reg_idx_t'(2'd3);

	// One input transaction as the predictor sees it.
	typedef struct packed {
		cmd_t                   command;
		logic [INDEX_W-1:0]     sensor_index;
		logic [SAMPLE_BITS-1:0] sample;
		logic                   restart;
	} sensor_item_t;

	// One result transaction, packed so that a single compare covers every field.
	typedef struct packed {
		logic [CAL_W-1:0]       calibrated_value;
		logic [SAMPLE_BITS-1:0] calib_min;
		logic [SAMPLE_BITS-1:0] calib_max;
		logic [POS_W-1:0]       position;
		logic                   position_valid;
	} reading_t;

	// Shapes of a measurement sweep used by the random part.
	typedef enum {SWEEP_NOISY, SWEEP_DARK_LINE, SWEEP_LIGHT_LINE, SWEEP_RAILS} sweep_shape_t;

	logic clk;
	logic arst_n;

	lspe_item_if #(.SAMPLE_BITS(SAMPLE_BITS)) item_ch ();
	lspe_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) res_ch ();
	lspe_cfg_if cfg_ch ();

	line_sensor_position_estimator #(
		.MAX_SENSORS(MAX_SENSORS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state: the calibration tables, the sweep accumulators and the two registers.
	logic [SAMPLE_BITS-1:0] low_bound [MAX_SENSORS];
	logic [SAMPLE_BITS-1:0] high_bound [MAX_SENSORS];
	logic [WSUM_W-1:0] dark_moment;
	logic [WGT_W-1:0]  dark_mass;
	logic [WSUM_W-1:0] light_moment;
	logic [WGT_W-1:0]  light_mass;
	logic [WGT_W-1:0]  bright_total;
	logic [COUNT_W-1:0] cfg_count;
	mode_t cfg_mode;

	// Readings still owed by the block, oldest first.
	reading_t expected_readings [$];

	int unsigned sent_items;
	int unsigned mismatch_count;
	int unsigned stall_left;
	bit idling;

	always begin
		clk = 1'b0;
		#(HALF_PERIOD);
		clk = 1'b1;
		#(HALF_PERIOD);
	end

	// Linear calibration of one raw sample against a sensor's bounds. Equal bounds give 0.
	// The low bound is tested first, so an uncalibrated sensor (low above high) reads 0 below
	// its low bound and full scale otherwise.
	function automatic int unsigned scaled_reading(int unsigned raw, int unsigned lo,
		int unsigned hi);
		int unsigned v;
		v = raw;
		if (lo == hi)
			return 0;
		if (v < lo)
			v = lo;
		else if (v > hi)
			v = hi;
		if (lo > hi)
			return (v == lo) ? 0 : SCALE_FULL;
		return ((v - lo) * SCALE_FULL) / (hi - lo);
	endfunction

	// Advances the predictor by one accepted transaction and returns the reading it causes.
	function automatic reading_t predict_reading(sensor_item_t it);
		reading_t r;
		int unsigned slot;
		int unsigned calv;
		int unsigned span;
		int unsigned moment;
		int unsigned mass;
		logic light;
		r = '0;
		slot = it.sensor_index;
		calv = 0;
		if (it.command == CMD_CAL) begin
			if (it.restart) begin
				low_bound[slot] = it.sample;
				high_bound[slot] = it.sample;
			end else begin
				if (it.sample < low_bound[slot])
					low_bound[slot] = it.sample;
				if (it.sample > high_bound[slot])
					high_bound[slot] = it.sample;
			end
		end else if (it.command == CMD_MEAS) begin
			// A count of zero acts as one sensor, a count beyond the array as the full array.
			span = cfg_count;
			if (span < 1)
				span = 1;
			if (span > MAX_SENSORS)
				span = MAX_SENSORS;
			calv = scaled_reading(it.sample, low_bound[slot], high_bound[slot]);
			// Sensor zero opens a new sweep.
			if (slot == 0) begin
				dark_moment = '0;
				dark_mass = '0;
				light_moment = '0;
				light_mass = '0;
				bright_total = '0;
			end
			// Only readings above the noise floor enter the moment and mass sums; all sums wrap at their widths.
			if (calv > NOISE_FLOOR) begin
				dark_moment = dark_moment + WSUM_W'(calv * slot * SCALE_FULL);
				dark_mass = dark_mass + WGT_W'(calv);
			end
			if (SCALE_FULL - calv > NOISE_FLOOR) begin
				light_moment = light_moment + WSUM_W'((SCALE_FULL - calv) * slot * SCALE_FULL);
				light_mass = light_mass + WGT_W'(SCALE_FULL - calv);
			end
			bright_total = bright_total + WGT_W'(calv);
			if (slot == span - 1) begin
				case (cfg_mode)
					MODE_DARK: light = 1'b0;
					MODE_LIGHT: light = 1'b1;
					default: light = (bright_total / span) > AUTO_THRESHOLD;
				endcase
				moment = light ? light_moment : dark_moment;
				mass = light ? light_mass : dark_mass;
				r.position = (mass == 0) ? {POS_W{1'b1}} : POS_W'(moment / mass);
				r.position_valid = 1'b1;
			end
		end
		r.calibrated_value = CAL_W'(calv);
		r.calib_min = low_bound[slot];
		r.calib_max = high_bound[slot];
		return r;
	endfunction

	function automatic sensor_item_t make_item(cmd_t command, int unsigned slot,
		int unsigned sample, bit restart);
		sensor_item_t it;
		it.command = command;
		it.sensor_index = INDEX_W'(slot);
		it.sample = SAMPLE_BITS'(sample);
		it.restart = restart;
		return it;
	endfunction

	// Any combination of the fields, spare command code included.
	function automatic sensor_item_t random_item();
		return make_item(cmd_t'($urandom_range(0, 3)), $urandom_range(0, MAX_SENSORS - 1),
			$urandom_range(0, FULL_CODE), $urandom_range(0, 1));
	endfunction

	// Presents one item at a falling edge, optionally after an idle burst, and waits for
	// the transaction. The expectation is queued at the accepting edge.
	task automatic send_item(input sensor_item_t it);
		@(negedge clk);
		if (idling && $urandom_range(0, 5) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.command <= it.command;
		item_ch.sensor_index <= it.sensor_index;
		item_ch.sample <= it.sample;
		item_ch.restart_calibration <= it.restart;
		do @(posedge clk); while (!item_ch.ready);
		expected_readings.push_back(predict_reading(it));
		sent_items++;
	endtask

	// Drops the item valid and waits until every owed reading has come back.
	task automatic settle_block();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (expected_readings.size() != 0) @(posedge clk);
	endtask

	// One register write transaction; the predictor takes the value at the accepting edge.
	task automatic write_reg(input reg_idx_t register, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= register;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (register == REG_SENSOR_COUNT)
			cfg_count = value;
		else if (register == REG_LINE_MODE)
			cfg_mode = mode_t'(value[MODE_W-1:0]);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// A calibration session: a restart sample per sensor, then some widening samples.
	task automatic calibrate_sensors(input int unsigned span);
		for (int unsigned s = 0; s < span; s++) begin
			send_item(make_item(CMD_CAL, s, $urandom_range(0, FULL_CODE / 2), 1'b1));
			repeat ($urandom_range(0, 3))
				send_item(make_item(CMD_CAL, s, $urandom_range(0, FULL_CODE), 1'b0));
			if ($urandom_range(0, 7) == 0)
				send_item(make_item(CMD_QUERY, s, $urandom_range(0, FULL_CODE),
					$urandom_range(0, 1)));
		end
	endtask

	// One measurement sweep over sensors 0 .. span-1, with the odd stray transaction and
	// the odd wrong index mixed in.
	task automatic run_sweep(input int unsigned span);
		sweep_shape_t shape;
		int unsigned center;
		int unsigned slot;
		int unsigned level;
		int unsigned gap;
		shape = sweep_shape_t'($urandom_range(0, 3));
		center = $urandom_range(0, span - 1);
		for (int unsigned s = 0; s < span; s++) begin
			if ($urandom_range(0, 24) == 0)
				send_item(random_item());
			slot = ($urandom_range(0, 29) == 0) ? $urandom_range(0, MAX_SENSORS - 1) : s;
			gap = (s > center) ? s - center : center - s;
			case (shape)
				SWEEP_NOISY: level = $urandom_range(0, FULL_CODE);
				SWEEP_DARK_LINE: level = (gap <= 1) ? $urandom_range(700, FULL_CODE)
					: $urandom_range(0, 250);
				SWEEP_LIGHT_LINE: level = (gap <= 1) ? $urandom_range(0, 250)
					: $urandom_range(700, FULL_CODE);
				default: level = $urandom_range(0, 1) ? FULL_CODE : 0;
			endcase
			send_item(make_item(CMD_MEAS, slot, level, $urandom_range(0, 1)));
		end
	endtask

	// Right after reset the tables read back as full-scale minimum and zero maximum, and an
	// uncalibrated sensor measures full scale only at the top code.
	task automatic test_reset_values();
		send_item(make_item(CMD_QUERY, 0, 0, 1'b0));
		send_item(make_item(CMD_SPARE, MAX_SENSORS - 1, FULL_CODE, 1'b1));
		send_item(make_item(CMD_MEAS, 5, FULL_CODE, 1'b0));
		send_item(make_item(CMD_MEAS, 6, 200, 1'b1));
	endtask

	// Restart and widening at the rails, equal bounds, and clamping at the low bound.
	task automatic test_calibration_edges();
		send_item(make_item(CMD_CAL, 0, 0, 1'b1));
		send_item(make_item(CMD_CAL, 0, FULL_CODE, 1'b0));
		send_item(make_item(CMD_CAL, 1, 512, 1'b1));
		send_item(make_item(CMD_CAL, 1, 512, 1'b0));
		send_item(make_item(CMD_CAL, 2, 100, 1'b1));
		send_item(make_item(CMD_CAL, 2, 900, 1'b0));
		send_item(make_item(CMD_MEAS, 2, 50, 1'b0));
	endtask

	// Three-sensor sweeps in each line mode, plus a sweep with nothing above the noise
	// floor, which reports no line.
	task automatic test_sweep_modes();
		settle_block();
		write_reg(REG_SENSOR_COUNT, CFG_DATA_W'(3));
		write_reg(REG_LINE_MODE, CFG_DATA_W'(MODE_DARK));
		send_item(make_item(CMD_MEAS, 0, FULL_CODE, 1'b0));
		send_item(make_item(CMD_MEAS, 1, 700, 1'b0));
		send_item(make_item(CMD_MEAS, 2, 500, 1'b0));
		send_item(make_item(CMD_MEAS, 0, 0, 1'b0));
		send_item(make_item(CMD_MEAS, 1, 300, 1'b0));
		send_item(make_item(CMD_MEAS, 2, 140, 1'b0));
		settle_block();
		write_reg(REG_LINE_MODE, CFG_DATA_W'(MODE_LIGHT));
		send_item(make_item(CMD_MEAS, 0, FULL_CODE, 1'b0));
		send_item(make_item(CMD_MEAS, 1, 700, 1'b0));
		send_item(make_item(CMD_MEAS, 2, 1000, 1'b0));
		settle_block();
		write_reg(REG_LINE_MODE, CFG_DATA_W'(MODE_SPARE));
		send_item(make_item(CMD_MEAS, 0, FULL_CODE, 1'b0));
		send_item(make_item(CMD_MEAS, 1, 700, 1'b0));
		send_item(make_item(CMD_MEAS, 2, 900, 1'b0));
	endtask

	// Phases of calibration and sweeps under changing register settings. The first phases
	// walk the count and mode extremes, the saturating counts among them.
	task automatic test_random_sessions(input int unsigned target);
		int unsigned count_plan [8] = '{1, 32, 0, 63, 8, 2, 31, 33};
		int unsigned phase;
		int unsigned count;
		int unsigned span;
		mode_t mode;
		phase = 0;
		while (sent_items < target) begin
			settle_block();
			if (phase < 8)
				count = count_plan[phase];
			else if ($urandom_range(0, 7) == 0)
				count = $urandom_range(0, 63);
			else
				count = $urandom_range(1, MAX_SENSORS);
			mode = (phase < 8) ? mode_t'(phase % 4) : mode_t'($urandom_range(0, 3));
			write_reg(REG_SENSOR_COUNT, CFG_DATA_W'(count));
			write_reg(REG_LINE_MODE, CFG_DATA_W'(mode));
			if (phase == 3)
				write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 63)));
			// Some phases run without any idling on either side.
			idling = ($urandom_range(0, 3) != 0);
			span = (count < 1) ? 1 : ((count > MAX_SENSORS) ? MAX_SENSORS : count);
			if (phase == 0 || $urandom_range(0, 2) != 0)
				calibrate_sensors(span);
			repeat (96 / span) run_sweep(span);
			phase++;
		end
	endtask

	// The closing stretch runs at full rate on both sides.
	task automatic test_back_to_back();
		settle_block();
		idling = 1'b0;
		write_reg(REG_SENSOR_COUNT, CFG_DATA_W'(8));
		write_reg(REG_LINE_MODE, CFG_DATA_W'(MODE_AUTO));
		calibrate_sensors(8);
		repeat (12) run_sweep(8);
	endtask

	// Result sink: ready drops for random bursts while idling is enabled.
	always @(negedge clk) begin
		if (stall_left == 0 && idling && $urandom_range(0, 15) == 0)
			stall_left = $urandom_range(1, 15);
		if (stall_left != 0) begin
			res_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Each result transaction is checked against the oldest owed reading.
	always @(posedge clk) begin : check_results
		reading_t got;
		reading_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.calibrated_value, res_ch.calib_min, res_ch.calib_max,
				res_ch.position, res_ch.position_valid};
			if (expected_readings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MISMATCH_REPORTS)
					$display("%0t: result with no reading owed: value %0d min %0d max %0d pos %0d",
						$realtime, got.calibrated_value, got.calib_min, got.calib_max,
						$signed(got.position));
			end else begin
				want = expected_readings.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= MISMATCH_REPORTS)
						$display(
							"%0t exp/act val %0d/%0d min %0d/%0d max %0d/%0d pos %0d/%0d v %0b/%0b",
							$realtime, want.calibrated_value, got.calibrated_value,
							want.calib_min, got.calib_min, want.calib_max, got.calib_max,
							$signed(want.position), $signed(got.position),
							want.position_valid, got.position_valid);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.command = CMD_CAL;
		item_ch.sensor_index = '0;
		item_ch.sample = '0;
		item_ch.restart_calibration = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_SENSOR_COUNT;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		stall_left = 0;
		idling = 1'b1;
		sent_items = 0;
		mismatch_count = 0;
		// Predictor after reset: empty ranges, cleared sums, eight sensors, dark line.
		for (int s = 0; s < MAX_SENSORS; s++) begin
			low_bound[s] = SAMPLE_BITS'(FULL_CODE);
			high_bound[s] = '0;
		end
		dark_moment = '0;
		dark_mass = '0;
		light_moment = '0;
		light_mass = '0;
		bright_total = '0;
		cfg_count = COUNT_W'(COUNT_RESET);
		cfg_mode = MODE_DARK;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_calibration_edges();
		test_sweep_modes();
		test_random_sessions(RANDOM_TARGET);
		test_back_to_back();

		// Wait for the last readings, then give the block time to show any stray result.
		settle_block();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_readings.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
